// ===== src/pffr_pkg.sv =====
// Package for the page fault FIFO replacer: action codes, microcode word
// layout and the microcode program table. No dependencies.
`default_nettype none

package pffr_pkg;

  // Bit position of the virtual page number inside a fault address.
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = 12;
  localparam int ADDR_W     = 32;
  localparam int BYTES_W    = 25;
  localparam int FRAME_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int STEP_W     = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTES = 1'd1;

  localparam logic [BYTES_W-1:0] WINDOW_BYTES_RST = 25'd16777216;

  typedef enum logic [2:0] {
    ACT_TLB_ADD    = 3'd0,
    ACT_TLB_DEL    = 3'd1,
    ACT_SWAP_STORE = 3'd2,
    ACT_SWAP_FETCH = 3'd3,
    ACT_ILLEGAL    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    VS_ZERO = 2'd0,
    VS_NEW  = 2'd1,
    VS_OLD  = 2'd2
  } vp_sel_t;

  typedef enum logic [1:0] {
    FS_ZERO = 2'd0,
    FS_PTR  = 2'd1,
    FS_MAP  = 2'd2
  } fr_sel_t;

  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_CLR_BUSY = 3'd2,
    C_NO_IN    = 3'd3,
    C_ILLEGAL  = 3'd4,
    C_PRESENT  = 3'd5,
    C_FREE     = 3'd6
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses.
  localparam step_t ST_CLR   = 4'd0;
  localparam step_t ST_IDLE  = 4'd1;
  localparam step_t ST_CHK1  = 4'd2;
  localparam step_t ST_CHK2  = 4'd3;
  localparam step_t ST_CHK3  = 4'd4;
  localparam step_t ST_CHK4  = 4'd5;
  localparam step_t ST_STORE = 4'd6;
  localparam step_t ST_DEL   = 4'd7;
  localparam step_t ST_FETCH = 4'd8;
  localparam step_t ST_ADD   = 4'd9;
  localparam step_t ST_HIT   = 4'd10;
  localparam step_t ST_ILL   = 4'd11;

  typedef struct packed {
    logic    accept;
    logic    chk;
    logic    clr_wr;
    logic    evict_wr;
    logic    map_wr;
    logic    emit;
    action_t act;
    vp_sel_t vsel;
    fr_sel_t fsel;
    logic    last;
    cond_t   cond;
    step_t   target;
  } ucode_t;

  // The microcode program, one control word per step.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{accept: 1'b0, chk: 1'b0, clr_wr: 1'b0, evict_wr: 1'b0, map_wr: 1'b0,
          emit: 1'b0, act: ACT_TLB_ADD, vsel: VS_ZERO, fsel: FS_ZERO,
          last: 1'b0, cond: C_NONE, target: ST_IDLE};
    case (step)
      ST_CLR: begin
        w.clr_wr = 1'b1;
        w.cond   = C_CLR_BUSY;
        w.target = ST_CLR;
      end
      ST_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_NO_IN;
        w.target = ST_IDLE;
      end
      ST_CHK1: begin
        w.chk = 1'b1;
      end
      ST_CHK2: begin
        w.cond   = C_ILLEGAL;
        w.target = ST_ILL;
      end
      ST_CHK3: begin
        w.cond   = C_PRESENT;
        w.target = ST_HIT;
      end
      ST_CHK4: begin
        w.cond   = C_FREE;
        w.target = ST_ADD;
      end
      ST_STORE: begin
        w.emit     = 1'b1;
        w.evict_wr = 1'b1;
        w.act      = ACT_SWAP_STORE;
        w.vsel     = VS_OLD;
        w.fsel     = FS_PTR;
      end
      ST_DEL: begin
        w.emit = 1'b1;
        w.act  = ACT_TLB_DEL;
        w.vsel = VS_OLD;
        w.fsel = FS_PTR;
      end
      ST_FETCH: begin
        w.emit = 1'b1;
        w.act  = ACT_SWAP_FETCH;
        w.vsel = VS_NEW;
        w.fsel = FS_PTR;
      end
      ST_ADD: begin
        w.emit   = 1'b1;
        w.map_wr = 1'b1;
        w.act    = ACT_TLB_ADD;
        w.vsel   = VS_NEW;
        w.fsel   = FS_PTR;
        w.last   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_HIT: begin
        w.emit   = 1'b1;
        w.act    = ACT_TLB_ADD;
        w.vsel   = VS_NEW;
        w.fsel   = FS_MAP;
        w.last   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_ILL: begin
        w.emit   = 1'b1;
        w.act    = ACT_ILLEGAL;
        w.last   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/page_fault_fifo_replacer_core.sv =====
// Top level of the page fault FIFO replacer: microcoded sequencer, page and
// frame tables, FIFO pointer and output register. Depends on pffr_pkg.
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      valid / stall      fault_address
// out_      output     valid / stall      action, virtual_page, frame, last
// cfg_      input      valid / ready      index, data (window_base, window_bytes)
//
// One fault is handled at a time by a microcode program stepping one word per
// cycle, except while an emitting step waits on out_stall. After the accepting
// step and the checks, one result is loaded for an illegal address, for a
// mapped page or for a free-frame claim; an eviction loads four results in turn
// (swap store, TLB delete, swap fetch, TLB add). The last result returns the
// program to the accepting step, where the next fault is taken.
// After reset a clearing pass writes every page table entry, one entry per
// cycle, before the first fault is taken.
// A stall on the output freezes the program at its emitting step; the
// configuration port is always ready.

module page_fault_fifo_replacer_core #(
  parameter int VIRT_PAGES  = 4096,
  parameter int PHYS_FRAMES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pffr_pkg::ADDR_W-1:0]     in_fault_address,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [2:0]                           out_action,
  output logic [pffr_pkg::PAGE_W-1:0]          out_virtual_page,
  output logic [pffr_pkg::FRAME_W-1:0]         out_frame,
  output logic                                 out_last,

  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pffr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pffr_pkg::ADDR_W-1:0]     cfg_data
);

  localparam int VW = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
  localparam int FW = (PHYS_FRAMES > 1) ? $clog2(PHYS_FRAMES) : 1;
  localparam logic [VW-1:0] CLR_LAST = VW'(VIRT_PAGES - 1);
  localparam logic [FW:0]   FRAMES_L = (FW + 1)'(PHYS_FRAMES);
  localparam logic [pffr_pkg::PAGE_W:0] PAGES_L = (pffr_pkg::PAGE_W + 1)'(VIRT_PAGES);

  // Configuration registers.
  logic [pffr_pkg::ADDR_W-1:0]  base_r;
  logic [pffr_pkg::BYTES_W-1:0] bytes_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      bytes_r <= pffr_pkg::WINDOW_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pffr_pkg::CFG_WINDOW_BASE:  base_r  <= cfg_data;
        pffr_pkg::CFG_WINDOW_BYTES: bytes_r <= cfg_data[pffr_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  pffr_pkg::step_t  step_r, step_nxt;
  pffr_pkg::ucode_t cw;
  logic             go;
  logic             jump;
  logic [VW-1:0]    clr_r;

  // Datapath registers.
  logic [pffr_pkg::ADDR_W-1:0] addr_r;
  logic [pffr_pkg::PAGE_W-1:0] vp_r;
  logic                        below_r;
  logic                        vp_big_r;
  logic [pffr_pkg::ADDR_W:0]   end_r;
  logic [FW-1:0]               ptr_r;
  logic                        wrapped_r;

  // Tables. Each page table entry holds a present bit over the frame number.
  logic [FW:0]                 pt_mem [VIRT_PAGES];
  logic [pffr_pkg::PAGE_W-1:0] own_mem [PHYS_FRAMES];
  logic [FW:0]                 pt_rd_r;
  logic [pffr_pkg::PAGE_W-1:0] own_rd_r;

  logic in_fire;
  logic illegal;

  assign cw       = pffr_pkg::ucode_rom(step_r);
  assign in_stall = !cw.accept;
  assign in_fire  = in_valid && !in_stall;

  // An emitting step waits while the result register is held by the sink.
  assign go = !(cw.emit && out_valid && out_stall);

  assign illegal = below_r || vp_big_r || ({1'b0, addr_r} >= end_r);

  always_comb begin
    case (cw.cond)
      pffr_pkg::C_NONE:     jump = 1'b0;
      pffr_pkg::C_ALWAYS:   jump = 1'b1;
      pffr_pkg::C_CLR_BUSY: jump = (clr_r != CLR_LAST);
      pffr_pkg::C_NO_IN:    jump = !in_valid;
      pffr_pkg::C_ILLEGAL:  jump = illegal;
      pffr_pkg::C_PRESENT:  jump = pt_rd_r[FW];
      pffr_pkg::C_FREE:     jump = !wrapped_r;
      default:              jump = 1'b0;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + pffr_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pffr_pkg::ST_CLR;
      clr_r  <= '0;
    end else begin
      step_r <= step_nxt;
      if (cw.clr_wr && (clr_r != CLR_LAST)) begin
        clr_r <= clr_r + VW'(1);
      end
    end
  end

  // Latch the fault and start both table reads in the accepting cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r   <= in_fault_address;
      vp_r     <= in_fault_address[pffr_pkg::PAGE_SHIFT +: pffr_pkg::PAGE_W];
      pt_rd_r  <= pt_mem[in_fault_address[pffr_pkg::PAGE_SHIFT +: VW]];
      own_rd_r <= own_mem[ptr_r];
    end
    if (cw.chk) begin
      below_r  <= (addr_r < base_r);
      end_r    <= {1'b0, base_r} + (pffr_pkg::ADDR_W + 1)'(bytes_r);
      vp_big_r <= ({1'b0, vp_r} >= PAGES_L);
    end
  end

  // Page table write port: clearing pass, eviction of the old owner, new map.
  always_ff @(posedge clk) begin
    if (cw.clr_wr) begin
      pt_mem[clr_r] <= '0;
    end else if (cw.evict_wr && go) begin
      pt_mem[own_rd_r[VW-1:0]] <= '0;
    end else if (cw.map_wr && go) begin
      pt_mem[vp_r[VW-1:0]] <= {1'b1, ptr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cw.map_wr && go) begin
      own_mem[ptr_r] <= vp_r;
    end
  end

  // FIFO pointer. Frames 1 upward are claimed in order, so each of them is in use once
  // the pointer has wrapped for the first time.
  logic [FW:0] ptr_inc;
  logic        ptr_wrap;

  assign ptr_inc  = {1'b0, ptr_r} + (FW + 1)'(1);
  assign ptr_wrap = (ptr_inc == FRAMES_L);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= FW'(1);
      wrapped_r <= 1'b0;
    end else if (cw.map_wr && go) begin
      ptr_r <= ptr_wrap ? FW'(1) : ptr_inc[FW-1:0];
      if (ptr_wrap) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // Result register.
  logic [pffr_pkg::PAGE_W-1:0] vp_mux;
  logic [FW-1:0]               fr_mux;
  logic [FW+7:0]               fr_wide;
  logic                        out_valid_r;

  always_comb begin
    case (cw.vsel)
      pffr_pkg::VS_NEW: vp_mux = vp_r;
      pffr_pkg::VS_OLD: vp_mux = own_rd_r;
      default:          vp_mux = '0;
    endcase
    case (cw.fsel)
      pffr_pkg::FS_PTR: fr_mux = ptr_r;
      pffr_pkg::FS_MAP: fr_mux = pt_rd_r[FW-1:0];
      default:          fr_mux = '0;
    endcase
  end

  assign fr_wide = {8'b0, fr_mux};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.emit && go) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && go) begin
      out_action       <= cw.act;
      out_virtual_page <= vp_mux;
      out_frame        <= fr_wide[pffr_pkg::FRAME_W-1:0];
      out_last         <= cw.last;
    end
  end

  assign out_valid = out_valid_r;

  // The pointer never names frame 0 nor a frame past the table.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r != '0) && ({1'b0, ptr_r} < FRAMES_L))
    else $error("fifo pointer out of range");

  // A final result returns the program to the accepting step.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.emit && go && cw.last) |=> (step_r == pffr_pkg::ST_IDLE))
    else $error("final result did not end the program");

  // Two faults are never accepted in consecutive cycles.
  a_one_fault: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_fire)
    else $error("fault accepted while one is in progress");

  // No result appears during the clearing pass.
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == pffr_pkg::ST_CLR) |-> !out_valid_r)
    else $error("result during clearing pass");

endmodule

`default_nettype wire

// ===== tb/tb_page_fault_fifo_replacer_core.sv =====
// Self-checking testbench for page_fault_fifo_replacer_core: window checks,
// FIFO frame claims, evictions and hits, predicted beat by beat against the
// output. Depends on pffr_pkg and the core RTL only.
module tb_page_fault_fifo_replacer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VIRT_PAGES  = 4096;
  localparam int PHYS_FRAMES = 256;
  // Even the slowest legal run (every fault an eviction, every beat held by
  // long output stalls, wide input gaps) finishes far below this.
  localparam int CYCLE_LIMIT = 400_000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // One fault beat waiting to be driven. A fault flagged wait_drain is held
  // back until every command still due from the block has come out.
  typedef struct {
    logic [pffr_pkg::ADDR_W-1:0] addr;
    bit                          wait_drain;
  } fault_t;

  // One command beat the block is expected to issue.
  typedef struct {
    pffr_pkg::action_t            act;
    logic [pffr_pkg::PAGE_W-1:0]  vp;
    logic [pffr_pkg::FRAME_W-1:0] frame;
    logic                         last;
  } tlb_cmd_t;

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic [pffr_pkg::ADDR_W-1:0]    in_fault_address = '0;
  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic [2:0]                     out_action;
  logic [pffr_pkg::PAGE_W-1:0]    out_virtual_page;
  logic [pffr_pkg::FRAME_W-1:0]   out_frame;
  logic                           out_last;
  logic                           cfg_valid        = 1'b0;
  logic                           cfg_ready;
  logic [pffr_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
  logic [pffr_pkg::ADDR_W-1:0]    cfg_data         = '0;

  page_fault_fifo_replacer_core #(
    .VIRT_PAGES (VIRT_PAGES),
    .PHYS_FRAMES(PHYS_FRAMES)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_fault_address(in_fault_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_virtual_page(out_virtual_page),
    .out_frame       (out_frame),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's window registers and tables. The page_frame
  // and frame_owner entries are only read once the matching present/used
  // bit says they hold something.
  logic [pffr_pkg::ADDR_W-1:0]  win_base  = '0;
  logic [pffr_pkg::BYTES_W-1:0] win_bytes = pffr_pkg::WINDOW_BYTES_RST;
  bit                           page_present[VIRT_PAGES];
  logic [pffr_pkg::FRAME_W-1:0] page_frame[VIRT_PAGES];
  bit                           frame_used[PHYS_FRAMES];
  logic [pffr_pkg::PAGE_W-1:0]  frame_owner[PHYS_FRAMES];
  int                           fifo_ptr = 1;

  fault_t                      faults_pending[$];
  tlb_cmd_t                    tlb_cmds_due[$];
  logic [pffr_pkg::ADDR_W-1:0] recent_addrs[$];
  idle_mode_t                  idle_mode = IDLE_NONE;
  int                          mismatches = 0;
  int                          cycle_count = 0;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void push_cmd(input pffr_pkg::action_t act,
                                   input logic [pffr_pkg::PAGE_W-1:0] vp,
                                   input int fr, input logic last);
    tlb_cmd_t c;
    c.act   = act;
    c.vp    = vp;
    c.frame = fr[pffr_pkg::FRAME_W-1:0];
    c.last  = last;
    tlb_cmds_due.push_back(c);
  endfunction

  // Works out the command beats one accepted fault causes and updates the
  // shadow tables the way the block must.
  function automatic void predict_fault(input logic [pffr_pkg::ADDR_W-1:0] addr);
    logic [pffr_pkg::ADDR_W:0]   win_end;
    logic [pffr_pkg::PAGE_W-1:0] vp;
    logic [pffr_pkg::PAGE_W-1:0] victim;
    int                          fr;
    // The window end is one bit wider, so a window running past the top of
    // the address space simply stops there instead of wrapping to zero.
    win_end = {1'b0, win_base} +
              {{(pffr_pkg::ADDR_W + 1 - pffr_pkg::BYTES_W){1'b0}}, win_bytes};
    vp      = addr[pffr_pkg::PAGE_SHIFT +: pffr_pkg::PAGE_W];
    if (addr < win_base || {1'b0, addr} >= win_end || int'(vp) >= VIRT_PAGES) begin
      push_cmd(pffr_pkg::ACT_ILLEGAL, '0, 0, 1'b1);
    end else if (page_present[vp]) begin
      push_cmd(pffr_pkg::ACT_TLB_ADD, vp, int'(page_frame[vp]), 1'b1);
    end else begin
      if (fifo_ptr < 1 || fifo_ptr >= PHYS_FRAMES) fifo_ptr = 1;
      fr = fifo_ptr;
      if (frame_used[fr]) begin
        // Eviction: the old owner is written out and unmapped before the
        // new page is fetched in. The frame stays marked used.
        victim = frame_owner[fr];
        page_present[victim] = 1'b0;
        push_cmd(pffr_pkg::ACT_SWAP_STORE, victim, fr, 1'b0);
        push_cmd(pffr_pkg::ACT_TLB_DEL, victim, fr, 1'b0);
        push_cmd(pffr_pkg::ACT_SWAP_FETCH, vp, fr, 1'b0);
      end
      push_cmd(pffr_pkg::ACT_TLB_ADD, vp, fr, 1'b1);
      frame_used[fr]   = 1'b1;
      frame_owner[fr]  = vp;
      page_present[vp] = 1'b1;
      page_frame[vp]   = fr[pffr_pkg::FRAME_W-1:0];
      fifo_ptr = fr + 1;
      if (fifo_ptr >= PHYS_FRAMES) fifo_ptr = 1;
    end
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 74;
      IDLE_BOTH: return $urandom_range(0, 99) < 15;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 74;
      IDLE_BOTH: return $urandom_range(0, 99) < 15;
      default:   return 1'b0;
    endcase
  endfunction

  // Fault driver. A beat completes at an edge where in_valid is high and
  // in_stall low; the prediction is made right there, so the expectation
  // order always matches the order the block took the faults in. A stalled
  // beat is held unchanged, and in_valid gets at most one assignment per edge.
  always @(posedge clk) begin : drive_faults
    fault_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_fault(in_fault_address);
      if (!in_valid || !in_stall) begin
        if (faults_pending.size() != 0 && !sender_gap() &&
            (!faults_pending[0].wait_drain || tlb_cmds_due.size() == 0)) begin
          nxt = faults_pending.pop_front();
          in_valid         <= 1'b1;
          in_fault_address <= nxt.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Command monitor. Each beat taken from the block is checked against the
  // oldest expectation; out_stall is redrawn every cycle so stalls land on
  // every step of the block's sequences.
  always @(posedge clk) begin : check_cmds
    tlb_cmd_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tlb_cmds_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat: action %0d vp %h frame %h last %b",
                                  out_action, out_virtual_page, out_frame, out_last));
        end else begin
          due = tlb_cmds_due.pop_front();
          if (out_action !== due.act || out_virtual_page !== due.vp ||
              out_frame !== due.frame || out_last !== due.last)
            flag_mismatch($sformatf({"got action %0d vp %h frame %h last %b, ",
                                     "want action %0d vp %h frame %h last %b"},
                                    out_action, out_virtual_page, out_frame, out_last,
                                    due.act, due.vp, due.frame, due.last));
        end
      end
      out_stall <= receiver_stall();
    end
  end

  // Watchdog: a lost or stuck beat ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_page_fault_fifo_replacer_core: done, errors");
      $finish;
    end
  end

  task automatic queue_fault(input logic [pffr_pkg::ADDR_W-1:0] addr,
                             input bit wait_drain = 1'b0);
    fault_t f;
    f.addr       = addr;
    f.wait_drain = wait_drain;
    faults_pending.push_back(f);
  endtask

  // Waits until every fault has been driven and every command has come out,
  // then lets the sequencer settle back to its idle step.
  task automatic wait_idle();
    do @(posedge clk);
    while (faults_pending.size() != 0 || in_valid || tlb_cmds_due.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  // Register beats only go out while the block is idle, so the shadow copy
  // is updated as soon as the beat completes.
  task automatic write_window_reg(input logic [pffr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pffr_pkg::ADDR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pffr_pkg::CFG_WINDOW_BASE) win_base = value;
    else win_bytes = value[pffr_pkg::BYTES_W-1:0];
  endtask

  task automatic set_window(input logic [pffr_pkg::ADDR_W-1:0] base,
                            input logic [pffr_pkg::BYTES_W-1:0] bytes);
    write_window_reg(pffr_pkg::CFG_WINDOW_BASE, base);
    write_window_reg(pffr_pkg::CFG_WINDOW_BYTES,
                     {{(pffr_pkg::ADDR_W - pffr_pkg::BYTES_W){1'b0}}, bytes});
  endtask

  // Random fault address, shaped by the current window. Most picks are fresh
  // pages inside the window, so the frame pool fills and evictions follow;
  // some revisit recent addresses (hits, or misses once evicted); the rest
  // are window edges and arbitrary addresses.
  function automatic logic [pffr_pkg::ADDR_W-1:0] pick_fault_addr();
    longint unsigned             span;
    int unsigned                 r;
    logic [pffr_pkg::ADDR_W-1:0] a;
    r    = $urandom_range(0, 99);
    span = longint'(win_bytes);
    if (64'h1_0000_0000 - longint'(win_base) < span) span = 64'h1_0000_0000 - win_base;
    if (r < 7 || span == 0) begin
      a = $urandom;
    end else if (r < 14) begin
      case ($urandom_range(0, 3))
        0:       a = win_base - 1;
        1:       a = win_base;
        2:       a = win_base + span[pffr_pkg::ADDR_W-1:0] - 1;
        default: a = win_base + span[pffr_pkg::ADDR_W-1:0];
      endcase
    end else if (r < 28 && recent_addrs.size() != 0) begin
      a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    end else begin
      a = win_base + $urandom_range(0, int'(span - 1));
      recent_addrs.push_back(a);
      if (recent_addrs.size() > 32) void'(recent_addrs.pop_front());
    end
    return a;
  endfunction

  task automatic run_random(input idle_mode_t mode, input int count);
    idle_mode = mode;
    repeat (count) queue_fault(pick_fault_addr(), $urandom_range(0, 39) == 0);
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window, base 0 and 16 MiB: first page claims frame 1, a second
    // touch hits, the last legal byte and the first illegal one, and the
    // all-ones and alternating address patterns.
    idle_mode = IDLE_NONE;
    queue_fault(32'h0000_0000);
    queue_fault(32'h0000_0ABC);
    queue_fault(32'h00FF_FFFF);
    queue_fault(32'h0100_0000);
    queue_fault(32'hFFFF_FFFF);
    queue_fault(32'h00FF_F000);
    queue_fault(32'h5555_5555);
    queue_fault(32'h0055_5555);
    queue_fault(32'h00AA_AAAA);
    wait_idle();

    // Window running past the top of the address space: it stops at the
    // top and does not wrap around to address zero.
    set_window(32'hFFFF_F000, pffr_pkg::WINDOW_BYTES_RST);
    queue_fault(32'hFFFF_F000);
    queue_fault(32'hFFFF_FFFF);
    queue_fault(32'hFFFF_EFFF);
    queue_fault(32'h0000_0000);
    wait_idle();

    // Empty window: nothing is legal.
    set_window(32'hFFFF_F000, '0);
    queue_fault(32'hFFFF_F000);
    queue_fault(32'hFFFF_FFFF);
    wait_idle();

    // One-byte windows, at the very top and somewhere in the middle.
    set_window(32'hFFFF_FFFF, 25'd1);
    queue_fault(32'hFFFF_FFFF);
    queue_fault(32'hFFFF_FFFE);
    wait_idle();
    set_window(32'h1234_5678, 25'd1);
    queue_fault(32'h1234_5677);
    queue_fault(32'h1234_5678);
    queue_fault(32'h1234_5679);
    wait_idle();

    // Random phases. The tables carry over between phases, so the frame
    // pool fills in the first ones and later misses evict.
    set_window('0, pffr_pkg::WINDOW_BYTES_RST);
    run_random(IDLE_NONE, 120);
    set_window($urandom, 25'($urandom_range(1 << 20, 1 << 24)));
    run_random(IDLE_SEND, 120);
    set_window(32'hFFFF_FFFF - $urandom_range(0, 1 << 22), pffr_pkg::WINDOW_BYTES_RST);
    run_random(IDLE_RECV, 120);
    set_window($urandom, 25'($urandom_range(1 << 16, 1 << 24)));
    run_random(IDLE_BOTH, 120);

    if (tlb_cmds_due.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never came", tlb_cmds_due.size()));
    if (mismatches == 0) begin
      $display("tb_page_fault_fifo_replacer_core: done, clean");
    end else begin
      $display("tb_page_fault_fifo_replacer_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pffr_pkg.sv
src/page_fault_fifo_replacer_core.sv
tb/tb_page_fault_fifo_replacer_core.sv
